FILE: rtl/core/knnmv_pkg.sv
`timescale 1ns / 1ps

package knnmv_pkg;

    // label field width, fixed by the word format
    localparam int LBL_W = 6;

    // default sizing
    localparam int NUM_CLASSES_DEF   = 64;
    localparam int MAX_NEIGHBORS_DEF = 64;

    typedef enum logic {
        VOTE_PLAIN = 1'b0,
        VOTE_FOCAL = 1'b1
    } t_vote_mode;

    // one input word as it sits in the compute stage
    typedef struct packed {
        logic [LBL_W-1:0] own_label;
        logic [LBL_W-1:0] neighbor_label;
        logic             neighbor_present;
        logic             last_neighbor;
    } t_item;

    // result of a finished point
    typedef struct packed {
        logic [LBL_W-1:0] new_label;
        logic             relabeled;
    } t_result;

endpackage

FILE: rtl/core/knn_majority_label_vote.sv
`timescale 1ns / 1ps

// k-nearest-neighbor label vote
// input words carry one neighbor label each, nearest first, with the focal
// point's own label alongside; i_last_neighbor marks the final word of a point.
// a word is taken when i_in_valid is high and o_in_stall is low; the result
// (new label and relabeled flag) leaves when o_out_valid is high and
// i_out_stall is low. only the marked word produces a result.
// throughput: one word per cycle while o_in_stall is low. each word is a
// read-modify-write of the class tally memory (registered read, write bypass on
// the read side). the result of a marked word is loaded into the output
// register when the word leaves the compute stage.
// the output register decouples the two sides; the input stalls only when a
// marked word is ready to finish while a previous result is still held by
// i_out_stall.
// i_cfg_we writes the vote mode (0 plain majority, 1 focal thresholded); write
// it only while the block is idle.
// reset (synchronous, active low) empties the pipe and the output register,
// clears the per-point state and sets plain majority mode. no clearing pass is
// needed: the tally memory is masked by per-class valid bits.
module knn_majority_label_vote #(
    parameter int NUM_CLASSES   = knnmv_pkg::NUM_CLASSES_DEF,
    parameter int MAX_NEIGHBORS = knnmv_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input word channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [knnmv_pkg::LBL_W-1:0] i_own_label,
    input  logic [knnmv_pkg::LBL_W-1:0] i_neighbor_label,
    input  logic                        i_neighbor_present,
    input  logic                        i_last_neighbor,
    // result word channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [knnmv_pkg::LBL_W-1:0] o_new_label,
    output logic                        o_relabeled,
    // mode register
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata
);

    localparam int CLS_W = $clog2(NUM_CLASSES);
    localparam int TAL_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int FS_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int ENT_W = FS_W + TAL_W;

    // mode register
    knnmv_pkg::t_vote_mode r_mode;

    // compute stage: the word whose tally read is in flight
    logic                  r_s_v;
    knnmv_pkg::t_item      r_s_item;

    // output register
    logic                        r_o_v;
    logic [knnmv_pkg::LBL_W-1:0] r_o_label;
    logic                        r_o_relab;

    logic                  accept;
    logic                  stage_go;
    logic                  res_load;
    logic                  wr_en;
    logic [CLS_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;
    logic [ENT_W-1:0]      rd_nb;
    logic [ENT_W-1:0]      rd_own;
    knnmv_pkg::t_result    vote_res;

    // a marked word can only finish when the output register frees up
    assign stage_go   = r_s_v && (!r_s_item.last_neighbor || !r_o_v || !i_out_stall);
    assign o_in_stall = r_s_v && !stage_go;
    assign accept     = i_in_valid && !o_in_stall;
    assign res_load   = stage_go && r_s_item.last_neighbor;

    // tally memory: word = {first seen position, count}, read at the
    // neighbor label and at the own label when a word is taken
    knnmv_tally_mem #(
        .DEPTH  (NUM_CLASSES),
        .DATA_W (ENT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_re      (accept),
        .i_raddr_a (CLS_W'(i_neighbor_label)),
        .i_raddr_b (CLS_W'(i_own_label)),
        .o_rdata_a (rd_nb),
        .o_rdata_b (rd_own)
    );

    // tally update, leader tracking and final decision
    knnmv_vote #(
        .NUM_CLASSES   (NUM_CLASSES),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_vote (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (stage_go),
        .i_item   (r_s_item),
        .i_mode   (r_mode),
        .i_rd_nb  (rd_nb),
        .i_rd_own (rd_own),
        .o_we     (wr_en),
        .o_waddr  (wr_addr),
        .o_wdata  (wr_data),
        .o_res    (vote_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= knnmv_pkg::VOTE_PLAIN;
            r_s_v  <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= knnmv_pkg::t_vote_mode'(i_cfg_wdata);
            end
            if (accept) begin
                r_s_v <= 1'b1;
            end else if (stage_go) begin
                r_s_v <= 1'b0;
            end
            if (res_load) begin
                r_o_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_item.own_label        <= i_own_label;
            r_s_item.neighbor_label   <= i_neighbor_label;
            r_s_item.neighbor_present <= i_neighbor_present;
            r_s_item.last_neighbor    <= i_last_neighbor;
        end
        if (res_load) begin
            r_o_label <= vote_res.new_label;
            r_o_relab <= vote_res.relabeled;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_new_label = r_o_label;
    assign o_relabeled = r_o_relab;

    // input backpressure only comes from a finished point blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s_v && r_s_item.last_neighbor && r_o_v && i_out_stall))
        else $error("input stalled without a blocked result");

    // the tally memory is only written by a word that leaves the stage
    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (stage_go && r_s_item.neighbor_present))
        else $error("tally write without a moving word");

    // a finished point reaches the output register on the next edge
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> (r_o_v && (o_relabeled == (o_new_label != $past(r_s_item.own_label)))))
        else $error("result missing or relabeled flag inconsistent");

    // a word that is not the last of its point never holds up the pipe
    a_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_v && !r_s_item.last_neighbor) |=> !$past(o_in_stall))
        else $error("non-final word stalled the input");

endmodule

FILE: rtl/core/knnmv_tally_mem.sv
`timescale 1ns / 1ps

module knnmv_tally_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 13,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read with write bypass, so a word read in the cycle of its update sees it
        if (i_re) begin
            r_rd_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
            r_rd_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

FILE: rtl/core/knnmv_vote.sv
`timescale 1ns / 1ps

module knnmv_vote #(
    parameter int NUM_CLASSES   = 64,
    parameter int MAX_NEIGHBORS = 64,
    localparam int CLS_W = $clog2(NUM_CLASSES),
    localparam int TAL_W = $clog2(MAX_NEIGHBORS + 1),
    localparam int FS_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
    localparam int ENT_W = FS_W + TAL_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  knnmv_pkg::t_item       i_item,
    input  knnmv_pkg::t_vote_mode  i_mode,
    input  logic [ENT_W-1:0]       i_rd_nb,
    input  logic [ENT_W-1:0]       i_rd_own,
    output logic                   o_we,
    output logic [CLS_W-1:0]       o_waddr,
    output logic [ENT_W-1:0]       o_wdata,
    output knnmv_pkg::t_result     o_res
);

    logic [NUM_CLASSES-1:0]          r_valid, n_valid;
    logic [TAL_W-1:0]                r_pos, n_pos, upd_pos;
    logic [TAL_W-1:0]                r_lead_tally, n_lead_tally, upd_lead_tally;
    logic [knnmv_pkg::LBL_W-1:0]     r_lead_class, n_lead_class, upd_lead_class;
    logic [FS_W-1:0]                 r_lead_fs, n_lead_fs, upd_lead_fs;

    logic [CLS_W-1:0]                nb_idx;
    logic [CLS_W-1:0]                own_idx;
    logic                            counted;
    logic                            nb_hit;
    logic                            own_hit;
    logic [TAL_W-1:0]                nb_tally;
    logic [FS_W-1:0]                 nb_fs;
    logic [TAL_W-1:0]                new_tally;
    logic                            take_lead;
    logic [TAL_W-1:0]                own_tally;
    logic [TAL_W:0]                  own_cnt;
    logic [TAL_W+1:0]                two_own;
    logic [TAL_W+1:0]                two_lead;
    logic [TAL_W+1:0]                k_ext;
    logic                            focal_win;
    logic [knnmv_pkg::LBL_W-1:0]     vote_label;

    assign nb_idx  = CLS_W'(i_item.neighbor_label);
    assign own_idx = CLS_W'(i_item.own_label);

    assign counted = i_item.neighbor_present
                  && (32'(i_item.neighbor_label) < NUM_CLASSES)
                  && (32'(r_pos) < MAX_NEIGHBORS);

    // an entry without its valid bit reads as a fresh tally
    assign nb_hit    = r_valid[nb_idx];
    assign nb_tally  = nb_hit ? i_rd_nb[TAL_W-1:0] : '0;
    assign nb_fs     = nb_hit ? i_rd_nb[ENT_W-1:TAL_W] : FS_W'(r_pos);
    assign new_tally = nb_tally + 1'b1;

    assign take_lead = counted
                    && ((new_tally > r_lead_tally)
                     || ((new_tally == r_lead_tally) && (nb_fs < r_lead_fs)));

    assign upd_pos        = counted ? (r_pos + 1'b1) : r_pos;
    assign upd_lead_tally = take_lead ? new_tally : r_lead_tally;
    assign upd_lead_class = take_lead ? i_item.neighbor_label : r_lead_class;
    assign upd_lead_fs    = take_lead ? nb_fs : r_lead_fs;

    // own count includes this word's neighbor when it matches
    assign own_hit   = (32'(i_item.own_label) < NUM_CLASSES) && r_valid[own_idx];
    assign own_tally = (counted && (i_item.neighbor_label == i_item.own_label)) ? new_tally
                     : (own_hit ? i_rd_own[TAL_W-1:0] : '0);
    assign own_cnt   = (TAL_W+1)'(own_tally) + (TAL_W+1)'(1);
    assign two_own   = {own_cnt, 1'b0};
    assign two_lead  = {1'b0, upd_lead_tally, 1'b0};
    assign k_ext     = (TAL_W+2)'(upd_pos);

    // a strict neighbor majority is always the leader
    assign focal_win = (two_lead > k_ext) && (two_own < k_ext)
                    && (upd_lead_class != i_item.own_label);

    always_comb begin
        vote_label = i_item.own_label;
        if (upd_pos != '0) begin
            case (i_mode)
                knnmv_pkg::VOTE_PLAIN: vote_label = upd_lead_class;
                knnmv_pkg::VOTE_FOCAL: vote_label = focal_win ? upd_lead_class
                                                              : i_item.own_label;
                default:               vote_label = i_item.own_label;
            endcase
        end
    end

    assign o_res.new_label = vote_label;
    assign o_res.relabeled = (vote_label != i_item.own_label);

    assign o_we    = i_go && counted;
    assign o_waddr = nb_idx;
    assign o_wdata = {nb_fs, new_tally};

    always_comb begin
        n_valid = r_valid;
        if (counted) begin
            n_valid[nb_idx] = 1'b1;
        end
        n_pos        = upd_pos;
        n_lead_tally = upd_lead_tally;
        n_lead_class = upd_lead_class;
        n_lead_fs    = upd_lead_fs;
        // point done: back to a clean slate
        if (i_item.last_neighbor) begin
            n_valid      = '0;
            n_pos        = '0;
            n_lead_tally = '0;
            n_lead_class = '0;
            n_lead_fs    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_pos        <= '0;
            r_lead_tally <= '0;
            r_lead_class <= '0;
            r_lead_fs    <= '0;
        end else if (i_go) begin
            r_valid      <= n_valid;
            r_pos        <= n_pos;
            r_lead_tally <= n_lead_tally;
            r_lead_class <= n_lead_class;
            r_lead_fs    <= n_lead_fs;
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_LABELS   = knnmv_pkg::NUM_CLASSES_DEF;
    localparam int NEIGHBOR_CAP = knnmv_pkg::MAX_NEIGHBORS_DEF;
    // cycles without any accepted word or result before the run is declared hung
    localparam int HANG_LIMIT   = 5000;
    // length of the receiver hold-off that backs the block up
    localparam int HOLD_CYCLES  = 80;

    // label vote predictor plus the queue of labels still owed by the block
    class vote_board;
        bit [6:0]              tally[NUM_LABELS];
        bit                    seen[NUM_LABELS];
        bit [5:0]              first_pos[NUM_LABELS];
        bit [6:0]              position;
        bit [5:0]              lead_class;
        bit [6:0]              lead_tally;
        bit [5:0]              lead_first;
        knnmv_pkg::t_vote_mode mode;
        knnmv_pkg::t_result    label_q[$];
        int                    errors;

        function new();
            clear_point();
            mode   = knnmv_pkg::VOTE_PLAIN;
            errors = 0;
        endfunction

        function void clear_point();
            foreach (seen[c]) begin
                seen[c]      = 1'b0;
                tally[c]     = '0;
                first_pos[c] = '0;
            end
            position   = '0;
            lead_class = '0;
            lead_tally = '0;
            lead_first = '0;
        endfunction

        function void set_mode(knnmv_pkg::t_vote_mode m);
            mode = m;
        endfunction

        function int outstanding();
            return label_q.size();
        endfunction

        function void count_neighbor(logic [5:0] c);
            if (position >= NEIGHBOR_CAP) return;
            if (!seen[c]) begin
                seen[c]      = 1'b1;
                tally[c]     = '0;
                first_pos[c] = position[5:0];
            end
            tally[c] = tally[c] + 7'd1;
            if (tally[c] > lead_tally ||
                (tally[c] == lead_tally && first_pos[c] < lead_first)) begin
                lead_class = c;
                lead_tally = tally[c];
                lead_first = first_pos[c];
            end
            position = position + 7'd1;
        endfunction

        // own label counted once; replaced only on a clear majority
        function logic [5:0] focal_vote(logic [5:0] own);
            int         own_count;
            int         top_count;
            int         t;
            int         k;
            int         c;
            logic [5:0] best;
            own_count = (seen[own] ? int'(tally[own]) : 0) + 1;
            best      = own;
            top_count = own_count;
            k         = position;
            for (c = 0; c < NUM_LABELS; c++) begin
                t = seen[c] ? int'(tally[c]) : 0;
                if (c == own) t = own_count;
                if (t > top_count) begin
                    best      = 6'(c);
                    top_count = t;
                end
            end
            if (2 * own_count < k && 2 * top_count > k) return best;
            return own;
        endfunction

        function void note_word(knnmv_pkg::t_item w);
            knnmv_pkg::t_result r;
            if (w.neighbor_present) count_neighbor(w.neighbor_label);
            if (!w.last_neighbor) return;
            if (position == 0)
                r.new_label = w.own_label;
            else if (mode == knnmv_pkg::VOTE_PLAIN)
                r.new_label = lead_class;
            else
                r.new_label = focal_vote(w.own_label);
            r.relabeled = (r.new_label != w.own_label);
            label_q.insert(label_q.size(), r);
            clear_point();
        endfunction

        function void check_result(logic [5:0] new_label, logic relabeled);
            knnmv_pkg::t_result exp_r;
            if (label_q.size() == 0) begin
                $error("unexpected result word: new_label %0d relabeled %0d",
                       new_label, relabeled);
                errors++;
                return;
            end
            exp_r = label_q.pop_front();
            if (new_label !== exp_r.new_label) begin
                $error("new_label mismatch: expected %0d, actual %0d",
                       exp_r.new_label, new_label);
                errors++;
            end
            if (relabeled !== exp_r.relabeled) begin
                $error("relabeled mismatch: expected %0d, actual %0d",
                       exp_r.relabeled, relabeled);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               rst_n;
    logic               in_valid;
    knnmv_pkg::t_item   in_word;
    logic               out_stall;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [5:0]         o_new_label;
    logic               o_relabeled;

    vote_board   board;
    bit          quiet;         // both sides stop idling while set
    int          hold_pending;  // bumped by the sender side to request a hold-off
    int          idle_cycles;

    knn_majority_label_vote dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_own_label        (in_word.own_label),
        .i_neighbor_label   (in_word.neighbor_label),
        .i_neighbor_present (in_word.neighbor_present),
        .i_last_neighbor    (in_word.last_neighbor),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_new_label        (o_new_label),
        .o_relabeled        (o_relabeled),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int served;
        int n;
        served    = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (served != hold_pending) begin
                served = hold_pending;
                // keep the output blocked so the block backs up and stalls its input
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 34);
            end
        end
    end

    // result checking and hang detection, sampled at the rising edge
    always @(posedge i_clk) begin
        if (rst_n === 1'b1) begin
            if (o_out_valid && !out_stall)
                board.check_result(o_new_label, o_relabeled);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("knn_majority_label_vote test failed");
                $finish;
            end
        end
    end

    // offer one word, idling at random first; returns on the falling edge
    // after it was taken
    task automatic send_word(input logic [5:0] own, input logic [5:0] nb,
                             input bit present, input bit last);
        knnmv_pkg::t_item w;
        w.own_label        = own;
        w.neighbor_label   = nb;
        w.neighbor_present = present;
        w.last_neighbor    = last;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 34) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        board.note_word(w);
        @(negedge i_clk);
    endtask

    // drain, let the pipe settle, then write the vote mode
    task automatic write_mode(input knnmv_pkg::t_vote_mode m);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        board.set_mode(m);
    endtask

    // random points: mostly short runs over a few classes so votes collide,
    // some empty points, a few runs past the neighbor cap
    task automatic run_points(input int n_words);
        int         sent;
        int         kind;
        int         count;
        int         pool_n;
        int         i;
        bit         wide;
        bit         present;
        logic [5:0] pool[4];
        logic [5:0] own;
        logic [5:0] tail;
        logic [5:0] nb;
        logic [5:0] own_now;
        sent = 0;
        while (sent < n_words) begin
            kind   = $urandom_range(0, 99);
            pool_n = $urandom_range(1, 4);
            foreach (pool[j]) pool[j] = 6'($urandom_range(0, 63));
            wide = ($urandom_range(0, 4) == 0);
            own  = $urandom_range(0, 1) ? pool[$urandom_range(0, pool_n - 1)]
                                        : 6'($urandom_range(0, 63));
            tail = 6'($urandom_range(0, 63));
            if (kind < 8)
                count = $urandom_range(1, 3);
            else if (kind < 11)
                count = $urandom_range(60, 80);
            else
                count = $urandom_range(1, 12);
            for (i = 0; i < count; i++) begin
                if (wide)
                    nb = 6'($urandom_range(0, 63));
                else if (count > 50 && i >= 50)
                    nb = tail;  // late labels, partly past the cap
                else
                    nb = pool[$urandom_range(0, pool_n - 1)];
                present = (kind < 8) ? 1'b0 : ($urandom_range(0, 9) != 0);
                // an odd own label on an unmarked word must not matter
                own_now = (i != count - 1 && $urandom_range(0, 19) == 0) ?
                          6'($urandom_range(0, 63)) : own;
                send_word(own_now, nb, present, i == count - 1);
                sent++;
            end
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        board        = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        quiet        = 1'b0;
        hold_pending = 0;
        idle_cycles  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // plain majority
        write_mode(knnmv_pkg::VOTE_PLAIN);
        send_word(6'd63, 6'd0, 1'b0, 1'b1);   // no neighbors keeps own label
        send_word(6'd0, 6'd5, 1'b1, 1'b0);    // 2-2 tie, first seen wins
        send_word(6'd0, 6'd7, 1'b1, 1'b0);
        send_word(6'd0, 6'd7, 1'b1, 1'b0);
        send_word(6'd0, 6'd5, 1'b1, 1'b1);
        send_word(6'd0, 6'd63, 1'b1, 1'b1);
        send_word(6'd63, 6'd0, 1'b1, 1'b1);
        send_word(6'd10, 6'd3, 1'b1, 1'b0);   // mark on an absent neighbor
        send_word(6'd10, 6'd9, 1'b0, 1'b1);
        send_word(6'd1, 6'd2, 1'b1, 1'b0);    // own label taken from the mark
        send_word(6'd2, 6'd2, 1'b1, 1'b1);
        in_valid <= 1'b0;

        // focal-inclusive majority
        write_mode(knnmv_pkg::VOTE_FOCAL);
        send_word(6'd4, 6'd9, 1'b1, 1'b0);    // clear majority relabels
        send_word(6'd4, 6'd9, 1'b1, 1'b0);
        send_word(6'd4, 6'd9, 1'b1, 1'b1);
        send_word(6'd4, 6'd9, 1'b1, 1'b0);    // own support blocks it
        send_word(6'd4, 6'd4, 1'b1, 1'b0);
        send_word(6'd4, 6'd9, 1'b1, 1'b1);
        send_word(6'd20, 6'd20, 1'b1, 1'b0);  // tie with own label
        send_word(6'd20, 6'd30, 1'b1, 1'b0);
        send_word(6'd20, 6'd30, 1'b1, 1'b1);
        send_word(6'd0, 6'd63, 1'b0, 1'b1);   // no neighbors
        send_word(6'd50, 6'd40, 1'b1, 1'b0);  // non-own tie, threshold holds
        send_word(6'd50, 6'd10, 1'b1, 1'b0);
        send_word(6'd50, 6'd63, 1'b0, 1'b1);
        in_valid <= 1'b0;

        // random phases across both modes
        write_mode(knnmv_pkg::VOTE_PLAIN);
        run_points(300);
        write_mode(knnmv_pkg::VOTE_FOCAL);
        quiet = 1'b1;                         // stretch with no idling at all
        run_points(300);
        quiet = 1'b0;
        write_mode(knnmv_pkg::VOTE_PLAIN);
        hold_pending++;                       // back the block up
        run_points(300);
        write_mode(knnmv_pkg::VOTE_FOCAL);
        hold_pending++;
        run_points(300);
        write_mode(knnmv_pkg::VOTE_PLAIN);
        run_points(300);

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("knn_majority_label_vote test passed");
        end else begin
            $display("knn_majority_label_vote test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/knnmv_pkg.sv
rtl/core/knnmv_tally_mem.sv
rtl/core/knnmv_vote.sv
rtl/core/knn_majority_label_vote.sv
bench/tb.sv
